/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/tce_pkg.sv */
// Package with sizes, opcodes and shared types of the execute unit.
`timescale 1ns / 1ps

package tce_pkg;

    localparam int NUM_REGS   = 16;
    localparam int MEM_WORDS  = 256;
    localparam int DATA_WIDTH = 32;

    localparam int REG_AW = $clog2(NUM_REGS);
    localparam int MEM_AW = $clog2(MEM_WORDS);

    localparam int ACTION_W = 3;
    localparam int REG_W    = 4;
    localparam int OPND_W   = 8;
    localparam int OUT_W    = 32;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [ACTION_W-1:0] OP_LDI = 3'd0;
    localparam logic [ACTION_W-1:0] OP_LDM = 3'd1;
    localparam logic [ACTION_W-1:0] OP_STM = 3'd2;
    localparam logic [ACTION_W-1:0] OP_ADD = 3'd3;
    localparam logic [ACTION_W-1:0] OP_SUB = 3'd4;
    localparam logic [ACTION_W-1:0] OP_MUL = 3'd5;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic              reg_we;
        logic [REG_AW-1:0] reg_addr;
        logic              mem_we;
        logic [MEM_AW-1:0] dm_addr;
        t_word             data;
    } t_wr_req;

endpackage

/* sv/tiny_cpu_execute_unit.sv */
// Top level of the execute unit: input stage, storage, ALU and result register.
//
//  Channel  | Direction | tdata fields, low bit first
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | action[2:0], dest_reg[6:3], operand[14:7], zero pad
//  m_axis   | out       | executed[0], written_value[32:1], zero pad
//
// One instruction per cycle while m_axis is not stalled. An accepted word is held in the read
// stage, where the register file and data memory are read, and then in the result register
// that drives m_axis. The multiply in the ALU between the read registers and the result
// register sets the clock period. Reset clears both pipeline stages and all storage valid
// bits. A stall on m_axis holds the result; the read stage still drains into the result
// register when it frees, so s_axis stays ready whenever either is free.
`timescale 1ns / 1ps

module tiny_cpu_execute_unit import tce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // action, dest_reg, operand, padding
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // executed, written_value, padding
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic                r_s1_vld;
    logic                n_s1_vld;
    logic [ACTION_W-1:0] r_s1_action;
    logic [REG_W-1:0]    r_s1_dest;
    logic [OPND_W-1:0]   r_s1_opnd;
    logic                r_out_vld;
    logic                n_out_vld;
    logic                r_out_exec;
    t_word               r_out_value;

    logic                accept;
    logic                s1_adv;
    logic [ACTION_W-1:0] in_action;
    logic [REG_W-1:0]    in_dest;
    logic [OPND_W-1:0]   in_opnd;
    t_word               rd_val;
    t_word               rs_val;
    t_word               mem_val;
    logic                alu_exec;
    logic                alu_reg_wr;
    logic                alu_mem_wr;
    t_word               alu_value;
    t_wr_req             wr;

    assign in_action = i_s_axis_tdata[ACTION_W-1:0];
    assign in_dest   = i_s_axis_tdata[ACTION_W +: REG_W];
    assign in_opnd   = i_s_axis_tdata[ACTION_W + REG_W +: OPND_W];

    assign s1_adv          = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_vld || s1_adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_s1_vld  = accept || (r_s1_vld && !s1_adv);
        n_out_vld = s1_adv || (r_out_vld && !i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= in_action;
            r_s1_dest   <= in_dest;
            r_s1_opnd   <= in_opnd;
        end
        if (s1_adv) begin
            r_out_exec  <= alu_exec;
            r_out_value <= alu_value;
        end
    end

    tce_storage u_storage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (in_dest),
        .i_rd_addr_b (in_opnd[OPND_W-1 -: REG_W]),
        .i_dm_addr   (in_opnd),
        .i_wr        (wr),
        .o_rd_a      (rd_val),
        .o_rd_b      (rs_val),
        .o_mem       (mem_val)
    );

    tce_alu u_alu (
        .i_action   (r_s1_action),
        .i_operand  (r_s1_opnd),
        .i_rd_val   (rd_val),
        .i_rs_val   (rs_val),
        .i_mem_val  (mem_val),
        .o_executed (alu_exec),
        .o_reg_wr   (alu_reg_wr),
        .o_mem_wr   (alu_mem_wr),
        .o_value    (alu_value)
    );

    // Writes to an index or address past the end of the store are dropped.
    always_comb begin
        wr.reg_we   = s1_adv && alu_reg_wr && ({1'b0, r_s1_dest} < (REG_W + 1)'(NUM_REGS));
        wr.reg_addr = r_s1_dest[REG_AW-1:0];
        wr.mem_we   = s1_adv && alu_mem_wr && ({1'b0, r_s1_opnd} < (OPND_W + 1)'(MEM_WORDS));
        wr.dm_addr  = r_s1_opnd[MEM_AW-1:0];
        wr.data     = alu_value;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_W - 1)'(0), OUT_W'(r_out_value), r_out_exec};

endmodule

/* sv/tce_ram.sv */
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps

module tce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write to one address in the same cycle return the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tce_storage.sv */
// Register file and data memory with valid bits and write forwarding.
`timescale 1ns / 1ps

module tce_storage import tce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [REG_W-1:0]  i_rd_addr_a,
    input  logic [REG_W-1:0]  i_rd_addr_b,
    input  logic [OPND_W-1:0] i_dm_addr,
    input  t_wr_req           i_wr,
    output t_word             o_rd_a,
    output t_word             o_rd_b,
    output t_word             o_mem
);

    logic [REG_W-1:0]     r_addr_a;
    logic [REG_W-1:0]     r_addr_b;
    logic [OPND_W-1:0]    r_maddr;
    logic [NUM_REGS-1:0]  r_reg_vld;
    logic [MEM_WORDS-1:0] r_mem_vld;
    t_wr_req              r_fwd;
    t_word                ram_a;
    t_word                ram_b;
    t_word                ram_m;
    logic                 a_in_range;
    logic                 b_in_range;
    logic                 m_in_range;
    logic [REG_AW-1:0]    a_idx;
    logic [REG_AW-1:0]    b_idx;
    logic [MEM_AW-1:0]    m_idx;

    // Two copies of the register file give two read ports; both take every write.
    tce_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_regs_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.reg_we),
        .i_waddr (i_wr.reg_addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr_a[REG_AW-1:0]),
        .o_rdata (ram_a)
    );

    tce_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_regs_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.reg_we),
        .i_waddr (i_wr.reg_addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr_b[REG_AW-1:0]),
        .o_rdata (ram_b)
    );

    tce_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (i_wr.mem_we),
        .i_waddr (i_wr.dm_addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_dm_addr[MEM_AW-1:0]),
        .o_rdata (ram_m)
    );

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
            r_maddr  <= i_dm_addr;
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
            r_mem_vld <= '0;
        end else begin
            if (i_wr.reg_we) begin
                r_reg_vld[i_wr.reg_addr] <= 1'b1;
            end
            if (i_wr.mem_we) begin
                r_mem_vld[i_wr.dm_addr] <= 1'b1;
            end
        end
    end

    // The only write a registered read can miss is the one made at the very edge of the
    // read, and that is always the latest write, so one entry of forwarding is enough.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd.reg_we <= 1'b0;
            r_fwd.mem_we <= 1'b0;
        end else if (i_wr.reg_we || i_wr.mem_we) begin
            r_fwd <= i_wr;
        end
    end

    assign a_idx      = r_addr_a[REG_AW-1:0];
    assign b_idx      = r_addr_b[REG_AW-1:0];
    assign m_idx      = r_maddr[MEM_AW-1:0];
    assign a_in_range = {1'b0, r_addr_a} < (REG_W + 1)'(NUM_REGS);
    assign b_in_range = {1'b0, r_addr_b} < (REG_W + 1)'(NUM_REGS);
    assign m_in_range = {1'b0, r_maddr} < (OPND_W + 1)'(MEM_WORDS);

    always_comb begin
        o_rd_a = '0;
        o_rd_b = '0;
        o_mem  = '0;
        if (a_in_range) begin
            if (r_fwd.reg_we && r_fwd.reg_addr == a_idx) begin
                o_rd_a = r_fwd.data;
            end else if (r_reg_vld[a_idx]) begin
                o_rd_a = ram_a;
            end
        end
        if (b_in_range) begin
            if (r_fwd.reg_we && r_fwd.reg_addr == b_idx) begin
                o_rd_b = r_fwd.data;
            end else if (r_reg_vld[b_idx]) begin
                o_rd_b = ram_b;
            end
        end
        if (m_in_range) begin
            if (r_fwd.mem_we && r_fwd.dm_addr == m_idx) begin
                o_mem = r_fwd.data;
            end else if (r_mem_vld[m_idx]) begin
                o_mem = ram_m;
            end
        end
    end

endmodule

/* sv/tce_alu.sv */
// Opcode decode and arithmetic for one instruction.
`timescale 1ns / 1ps

module tce_alu import tce_pkg::*; (
    input  logic [ACTION_W-1:0] i_action,
    input  logic [OPND_W-1:0]   i_operand,
    input  t_word               i_rd_val,
    input  t_word               i_rs_val,
    input  t_word               i_mem_val,
    output logic                o_executed,
    output logic                o_reg_wr,
    output logic                o_mem_wr,
    output t_word               o_value
);

    always_comb begin
        o_executed = 1'b1;
        o_reg_wr   = 1'b1;
        o_mem_wr   = 1'b0;
        o_value    = '0;
        case (i_action)
            OP_LDI: o_value = DATA_WIDTH'(i_operand);
            OP_LDM: o_value = i_mem_val;
            OP_STM: begin
                o_value  = i_rd_val;
                o_reg_wr = 1'b0;
                o_mem_wr = 1'b1;
            end
            OP_ADD: o_value = i_rd_val + i_rs_val;
            OP_SUB: o_value = i_rd_val - i_rs_val;
            OP_MUL: o_value = i_rd_val * i_rs_val;
            default: begin
                o_executed = 1'b0;
                o_reg_wr   = 1'b0;
            end
        endcase
    end

endmodule

/* sv/tce_checker.sv */
// Port-level checker for the execute unit, attached by bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tce_checker import tce_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    logic m_stall;
    logic s_idle_word;

    assign m_stall     = i_m_tvalid && !i_m_tready;
    assign s_idle_word = i_s_tvalid && i_s_tdata[ACTION_W-1:0] == OP_LDI;

    // Reset empties the result register.
    `ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !i_m_tvalid)

    // With no result pending, the unit always takes a new word.
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !i_m_tvalid, i_s_tready)

    // An instruction that did not execute reports a zero value and zero padding.
    `ASSERT_IMPL(a_noexec_zero, i_clk, i_rst_n, i_m_tvalid && !i_m_tdata[0],
                 i_m_tdata[OUT_TDATA_W-1:1] == '0)

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, i_m_tvalid && $stable(i_m_tdata))

    // A load immediate presented while the output is empty passes straight in.
    `ASSERT_IMPL(a_ldi_taken, i_clk, i_rst_n, s_idle_word && !i_m_tvalid, i_s_tready)

endmodule

bind tiny_cpu_execute_unit tce_checker u_tce_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tdata  (i_s_axis_tdata),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

/* tb/tiny_cpu_execute_unit_test.sv */
// Self-checking testbench for the execute unit: predicts each result word and compares it.
`timescale 1ns / 1ps

module tiny_cpu_execute_unit_test;
    import tce_pkg::*;

    // Opcodes 6 and 7 are not executable.
    localparam logic [ACTION_W-1:0] OP_BAD_LO = 3'd6;
    localparam logic [ACTION_W-1:0] OP_BAD_HI = 3'd7;
    localparam int IDLE_PCT    = 9;
    localparam int HOLD_START  = 250;
    localparam int HOLD_CYCLES = 80;
    localparam int CALM_START  = 500;
    localparam int CALM_END    = 700;
    localparam int NUM_RANDOM  = 750;

    typedef struct packed {
        logic [OPND_W-1:0]   operand;
        logic [REG_W-1:0]    dest_reg;
        logic [ACTION_W-1:0] action;
    } t_instr;

    typedef struct packed {
        logic  executed;
        t_word written_value;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_instr   pending_instrs[$];
    t_outcome expected_outcomes[$];
    t_word    reg_model[NUM_REGS];
    t_word    mem_model[MEM_WORDS];
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    int       hold_left = 0;

    tiny_cpu_execute_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Applies one instruction to the shadow state and returns the word it should produce.
    function automatic t_outcome execute_instr(input t_instr ins);
        t_outcome res;
        t_word    rd_val;
        t_word    rs_val;
        rd_val = reg_model[ins.dest_reg];
        rs_val = reg_model[ins.operand[7:4]];
        res.executed = 1'b1;
        res.written_value = '0;
        case (ins.action)
            OP_LDI: begin
                res.written_value = t_word'(ins.operand);
                reg_model[ins.dest_reg] = res.written_value;
            end
            OP_LDM: begin
                res.written_value = mem_model[ins.operand];
                reg_model[ins.dest_reg] = res.written_value;
            end
            OP_STM: begin
                res.written_value = rd_val;
                mem_model[ins.operand] = res.written_value;
            end
            OP_ADD: begin
                res.written_value = rd_val + rs_val;
                reg_model[ins.dest_reg] = res.written_value;
            end
            OP_SUB: begin
                res.written_value = rd_val - rs_val;
                reg_model[ins.dest_reg] = res.written_value;
            end
            OP_MUL: begin
                res.written_value = rd_val * rs_val;
                reg_model[ins.dest_reg] = res.written_value;
            end
            default: begin
                res.executed = 1'b0;
            end
        endcase
        return res;
    endfunction

    function automatic t_instr make_instr(input logic [ACTION_W-1:0] act,
                                          input int rd, input int opnd);
        t_instr ins;
        ins.action = act;
        ins.dest_reg = rd[REG_W-1:0];
        ins.operand = opnd[OPND_W-1:0];
        return ins;
    endfunction

    // Sender: a word stays on the bus until it is taken.
    always @(posedge i_clk) begin
        t_instr nxt;
        logic   calm;
        calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_instrs.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = pending_instrs.pop_front();
                i_s_axis_tdata <= {{(IN_TDATA_W - $bits(t_instr)){1'b0}}, nxt};
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (cycle_cnt == HOLD_START) begin
            hold_left = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (cycle_cnt >= CALM_START && cycle_cnt < CALM_END) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Checks each result word against the oldest prediction, then predicts the accepted input.
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.executed = o_m_axis_tdata[0];
                got.written_value = o_m_axis_tdata[OUT_W:1];
                if (expected_outcomes.size() == 0) begin
                    $error("result word with no instruction outstanding");
                    mismatch_cnt++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.executed !== want.executed) begin
                        $error("executed: expected %0b, got %0b", want.executed, got.executed);
                        mismatch_cnt++;
                    end
                    if (got.written_value !== want.written_value) begin
                        $error("written_value: expected %0d, got %0d",
                               $signed(want.written_value), $signed(got.written_value));
                        mismatch_cnt++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_outcomes.push_back(
                    execute_instr(t_instr'(i_s_axis_tdata[$bits(t_instr)-1:0])));
            end
        end
    end

    initial begin
        int sel;
        int addr;
        logic [ACTION_W-1:0] act;

        foreach (reg_model[i]) reg_model[i] = '0;
        foreach (mem_model[i]) mem_model[i] = '0;

        // Directed part: field extremes, wrap-around in every arithmetic operation, invalid opcodes.
        pending_instrs.push_back(make_instr(OP_LDI, 0, 8'h00));
        pending_instrs.push_back(make_instr(OP_LDI, 15, 8'hFF));
        pending_instrs.push_back(make_instr(OP_LDI, 1, 8'h01));
        pending_instrs.push_back(make_instr(OP_MUL, 15, 8'hF0));
        pending_instrs.push_back(make_instr(OP_MUL, 15, 8'hF0));
        pending_instrs.push_back(make_instr(OP_MUL, 15, 8'hF0));
        pending_instrs.push_back(make_instr(OP_ADD, 15, 8'hF0));
        pending_instrs.push_back(make_instr(OP_SUB, 0, 8'hF0));
        pending_instrs.push_back(make_instr(OP_SUB, 0, 8'h00));
        pending_instrs.push_back(make_instr(OP_SUB, 0, 8'h10));
        pending_instrs.push_back(make_instr(OP_ADD, 0, 8'h1F));
        pending_instrs.push_back(make_instr(OP_STM, 15, 8'hFF));
        pending_instrs.push_back(make_instr(OP_STM, 0, 8'h00));
        pending_instrs.push_back(make_instr(OP_LDM, 2, 8'hFF));
        pending_instrs.push_back(make_instr(OP_LDM, 3, 8'h80));
        pending_instrs.push_back(make_instr(OP_ADD, 2, 8'h3F));
        pending_instrs.push_back(make_instr(OP_BAD_LO, 15, 8'hFF));
        pending_instrs.push_back(make_instr(OP_BAD_HI, 0, 8'h00));
        pending_instrs.push_back(make_instr(OP_BAD_HI, 15, 8'hFF));
        pending_instrs.push_back(make_instr(OP_LDI, 7, 8'h55));
        pending_instrs.push_back(make_instr(OP_MUL, 7, 8'h2A));
        pending_instrs.push_back(make_instr(OP_STM, 2, 8'h01));
        pending_instrs.push_back(make_instr(OP_LDM, 8, 8'h01));

        // Random part: addresses cluster low so loads mostly see stored data.
        repeat (NUM_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) act = OP_LDI;
            else if (sel < 29) act = OP_LDM;
            else if (sel < 43) act = OP_STM;
            else if (sel < 57) act = OP_ADD;
            else if (sel < 71) act = OP_SUB;
            else if (sel < 85) act = OP_MUL;
            else if (sel < 93) act = OP_BAD_LO;
            else act = OP_BAD_HI;
            if ((act == OP_LDM || act == OP_STM) && $urandom_range(0, 99) < 60)
                addr = $urandom_range(0, 15);
            else
                addr = $urandom_range(0, 255);
            pending_instrs.push_back(make_instr(act, $urandom_range(0, 15), addr));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_instrs.size() > 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_outcomes.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("[tiny_cpu_execute_unit] OK");
        end else begin
            $display("[tiny_cpu_execute_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[tiny_cpu_execute_unit] ERROR");
        $finish;
    end

endmodule

/* tiny_cpu_execute_unit.f */
+incdir+sv
sv/tce_pkg.sv
sv/tce_ram.sv
sv/tce_storage.sv
sv/tce_alu.sv
sv/tiny_cpu_execute_unit.sv
sv/tce_checker.sv
tb/tiny_cpu_execute_unit_test.sv
